[src/wsts_pkg.sv]
// shared constants, types and helpers for the work stealing task scheduler
// no dependencies
package wsts_pkg;

   localparam int NUM_CORES   = 4;
   localparam int QUEUE_DEPTH = 16;

   localparam int STORE_DEPTH = NUM_CORES * QUEUE_DEPTH;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int CIDX_W      = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

   localparam int OP_W   = 2;
   localparam int TASK_W = 16;
   localparam int CORE_W = 3;
   localparam int KIND_W = 4;
   localparam int ACT_W  = 4;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [TASK_W-1:0] task_type;
   typedef logic [CORE_W-1:0] core_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [ACT_W-1:0]  act_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [CIDX_W-1:0] cidx_type;

   localparam act_type ACT_RESET = 4'd4;

   localparam op_type OP_ADD   = 2'd0;
   localparam op_type OP_RUN   = 2'd1;
   localparam op_type OP_SLEEP = 2'd2;
   localparam op_type OP_SHUT  = 2'd3;

   localparam kind_type EV_ASSIGNED = 4'd0;
   localparam kind_type EV_RAN      = 4'd1;
   localparam kind_type EV_STOLE    = 4'd2;
   localparam kind_type EV_IDLE     = 4'd3;
   localparam kind_type EV_MOVED    = 4'd4;
   localparam kind_type EV_NOTASKS  = 4'd5;
   localparam kind_type EV_DELETED  = 4'd6;
   localparam kind_type EV_NONE     = 4'd7;
   localparam kind_type EV_FULL     = 4'd8;
   localparam kind_type EV_DROPPED  = 4'd9;

   function automatic addr_type store_addr(input cidx_type core, input ptr_type pos);
      store_addr = addr_type'(core) * addr_type'(QUEUE_DEPTH) + addr_type'(pos);
   endfunction

   function automatic ptr_type push_pos(input ptr_type head);
      push_pos = (head == '0) ? ptr_type'(QUEUE_DEPTH - 1) : head - ptr_type'(1);
   endfunction

   function automatic ptr_type next_pos(input ptr_type head);
      next_pos = (head == ptr_type'(QUEUE_DEPTH - 1)) ? '0 : head + ptr_type'(1);
   endfunction

   function automatic ptr_type back_pos(input ptr_type head, input cnt_type cnt);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(cnt) - SUM_W'(1);
      if (s >= SUM_W'(QUEUE_DEPTH)) begin
         s = s - SUM_W'(QUEUE_DEPTH);
      end
      back_pos = s[PTR_W-1:0];
   endfunction

endpackage

[src/wsts_ram.sv]
// generic single port write, single port read ram with registered read
// no dependencies
module wsts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                       write_data,
   input  logic                                   read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                       read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

[src/wsts_ctrl.sv]
// command sequencer: deque heads and counts, load scans, task store access
// depends on wsts_pkg, drives one wsts_ram
module wsts_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  wsts_pkg::act_type live_cores,
   input  logic              start,
   output logic              busy,
   input  wsts_pkg::op_type  req_op,
   input  wsts_pkg::task_type req_task_id,
   input  wsts_pkg::core_type req_core_index,
   output logic              ram_we,
   output wsts_pkg::addr_type ram_waddr,
   output wsts_pkg::task_type ram_wdata,
   output logic              ram_re,
   output wsts_pkg::addr_type ram_raddr,
   input  wsts_pkg::task_type ram_rdata,
   output logic              rsp_valid,
   output wsts_pkg::kind_type rsp_event_kind,
   output wsts_pkg::core_type rsp_event_core,
   output wsts_pkg::task_type rsp_event_task,
   output logic              rsp_last_event
);
   import wsts_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_RESP   = 2'd2;

   logic [1:0] state_ff, state_in;
   op_type     op_ff, op_in;
   task_type   task_ff, task_in;
   core_type   core_ff, core_in;
   kind_type   pend_kind_ff, pend_kind_in;
   cidx_type   pend_core_ff, pend_core_in;
   ptr_type    head_ff [NUM_CORES];
   ptr_type    head_in [NUM_CORES];
   cnt_type    count_ff [NUM_CORES];
   cnt_type    count_in [NUM_CORES];
   logic       valid_ff, valid_in;
   kind_type   kind_ff, kind_in;
   core_type   ecore_ff, ecore_in;
   task_type   etask_ff, etask_in;
   logic       last_ff, last_in;

   cidx_type ci, ll_all, ll_other, most, first_busy;
   logic     ll_found, any_busy, core_ok;

   assign ci      = core_ff[CIDX_W-1:0];
   assign core_ok = ({1'b0, core_ff} < live_cores);

   // load scans over the deque counts
   always_comb begin
      logic fa, fo;
      fa = 1'b0;
      fo = 1'b0;
      ll_all = '0;
      ll_other = '0;
      most = '0;
      first_busy = '0;
      any_busy = 1'b0;
      for (int i = 0; i < NUM_CORES; i++) begin
         if (act_type'(i) < live_cores) begin
            if (!fa || count_ff[i] < count_ff[ll_all]) begin
               ll_all = cidx_type'(i);
               fa = 1'b1;
            end
            if (cidx_type'(i) != ci && (!fo || count_ff[i] < count_ff[ll_other])) begin
               ll_other = cidx_type'(i);
               fo = 1'b1;
            end
            if (count_ff[i] > count_ff[most]) begin
               most = cidx_type'(i);
            end
         end
      end
      for (int i = NUM_CORES - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            first_busy = cidx_type'(i);
            any_busy = 1'b1;
         end
      end
      ll_found = fo;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      task_in = task_ff;
      core_in = core_ff;
      pend_kind_in = pend_kind_ff;
      pend_core_in = pend_core_ff;
      head_in = head_ff;
      count_in = count_ff;
      valid_in = 1'b0;
      kind_in = kind_ff;
      ecore_in = ecore_ff;
      etask_in = etask_ff;
      last_in = last_ff;
      ram_we = 1'b0;
      ram_waddr = '0;
      ram_wdata = ram_rdata;
      ram_re = 1'b0;
      ram_raddr = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_op;
               task_in = req_task_id;
               core_in = req_core_index;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            valid_in = 1'b1;
            last_in = 1'b1;
            etask_in = '0;
            ecore_in = core_ff;
            case (op_ff)
               OP_ADD: begin
                  ecore_in = core_type'(ll_all);
                  etask_in = task_ff;
                  if (count_ff[ll_all] == cnt_type'(QUEUE_DEPTH)) begin
                     kind_in = EV_FULL;
                  end else begin
                     kind_in = EV_ASSIGNED;
                     ram_we = 1'b1;
                     ram_waddr = store_addr(ll_all, push_pos(head_ff[ll_all]));
                     ram_wdata = task_ff;
                     head_in[ll_all] = push_pos(head_ff[ll_all]);
                     count_in[ll_all] = count_ff[ll_all] + cnt_type'(1);
                  end
               end
               OP_RUN: begin
                  kind_in = EV_IDLE;
                  if (core_ok && count_ff[ci] != '0) begin
                     valid_in = 1'b0;
                     ram_re = 1'b1;
                     ram_raddr = store_addr(ci, back_pos(head_ff[ci], count_ff[ci]));
                     count_in[ci] = count_ff[ci] - cnt_type'(1);
                     pend_kind_in = EV_RAN;
                     pend_core_in = ci;
                     state_in = S_RESP;
                  end else if (core_ok && count_ff[most] != '0) begin
                     valid_in = 1'b0;
                     ram_re = 1'b1;
                     ram_raddr = store_addr(most, back_pos(head_ff[most], count_ff[most]));
                     count_in[most] = count_ff[most] - cnt_type'(1);
                     pend_kind_in = EV_STOLE;
                     pend_core_in = ci;
                     state_in = S_RESP;
                  end
               end
               OP_SLEEP: begin
                  kind_in = EV_NOTASKS;
                  if (core_ok && count_ff[ci] != '0) begin
                     valid_in = 1'b0;
                     ram_re = 1'b1;
                     ram_raddr = store_addr(ci, head_ff[ci]);
                     head_in[ci] = next_pos(head_ff[ci]);
                     count_in[ci] = count_ff[ci] - cnt_type'(1);
                     pend_kind_in = EV_MOVED;
                     pend_core_in = ci;
                     state_in = S_RESP;
                  end
               end
               default: begin
                  kind_in = EV_NONE;
                  ecore_in = '0;
                  if (any_busy) begin
                     valid_in = 1'b0;
                     ram_re = 1'b1;
                     ram_raddr = store_addr(first_busy,
                                            back_pos(head_ff[first_busy], count_ff[first_busy]));
                     count_in[first_busy] = count_ff[first_busy] - cnt_type'(1);
                     pend_kind_in = EV_DELETED;
                     pend_core_in = first_busy;
                     state_in = S_RESP;
                  end
               end
            endcase
         end
         S_RESP: begin
            valid_in = 1'b1;
            etask_in = ram_rdata;
            ecore_in = core_type'(pend_core_ff);
            kind_in = pend_kind_ff;
            last_in = 1'b1;
            state_in = S_IDLE;
            case (pend_kind_ff)
               EV_STOLE: begin
                  ram_we = 1'b1;
                  ram_waddr = store_addr(pend_core_ff, push_pos(head_ff[pend_core_ff]));
                  head_in[pend_core_ff] = push_pos(head_ff[pend_core_ff]);
                  count_in[pend_core_ff] = count_ff[pend_core_ff] + cnt_type'(1);
               end
               EV_MOVED: begin
                  last_in = (count_ff[ci] == '0);
                  state_in = last_in ? S_IDLE : S_DECIDE;
                  if (!ll_found || count_ff[ll_other] == cnt_type'(QUEUE_DEPTH)) begin
                     kind_in = EV_DROPPED;
                     ecore_in = core_ff;
                  end else begin
                     ecore_in = core_type'(ll_other);
                     ram_we = 1'b1;
                     ram_waddr = store_addr(ll_other, push_pos(head_ff[ll_other]));
                     head_in[ll_other] = push_pos(head_ff[ll_other]);
                     count_in[ll_other] = count_ff[ll_other] + cnt_type'(1);
                  end
               end
               EV_DELETED: begin
                  last_in = !any_busy;
                  state_in = last_in ? S_IDLE : S_DECIDE;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CORES; i++) begin
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         head_ff <= head_in;
         count_ff <= count_in;
      end
      op_ff <= op_in;
      task_ff <= task_in;
      core_ff <= core_in;
      pend_kind_ff <= pend_kind_in;
      pend_core_ff <= pend_core_in;
      kind_ff <= kind_in;
      ecore_ff <= ecore_in;
      etask_ff <= etask_in;
      last_ff <= last_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_event_core = ecore_ff;
   assign rsp_event_task = etask_ff;
   assign rsp_last_event = last_ff;

`ifndef SYNTH
   a_read_then_resp: assert property (@(posedge clock) disable iff (reset)
      ram_re |=> state_ff == S_RESP)
      else $error("store read not followed by response step");
   a_no_read_write: assert property (@(posedge clock) disable iff (reset)
      !(ram_re && ram_we))
      else $error("store read and write in one cycle");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> state_ff == S_IDLE)
      else $error("last transfer while still busy");
`endif
endmodule

[src/work_stealing_task_scheduler_top.sv]
// top level of the work stealing task scheduler: csr register, sequencer, task store
// depends on wsts_pkg, wsts_ctrl and wsts_ram
//
// A command is taken when start is high and busy is low; busy stays high until the
// last result of that command has been issued. Results come out one per strobe on
// rsp_valid and cannot be stalled; rsp_last_event marks the final one. Every command
// passes a decide step; each task that run, sleep or shutdown takes out of a deque is
// read from the task store and then issued from a response step.
module work_stealing_task_scheduler_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  wsts_pkg::act_type  csr_write_data,
   input  logic               start,
   output logic               busy,
   input  wsts_pkg::op_type   req_op,
   input  wsts_pkg::task_type req_task_id,
   input  wsts_pkg::core_type req_core_index,
   output logic               rsp_valid,
   output wsts_pkg::kind_type rsp_event_kind,
   output wsts_pkg::core_type rsp_event_core,
   output wsts_pkg::task_type rsp_event_task,
   output logic               rsp_last_event
);
   import wsts_pkg::*;

   act_type  active_ff;
   act_type  live;
   logic     ram_we, ram_re;
   addr_type ram_waddr, ram_raddr;
   task_type ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACT_RESET;
      end else if (csr_write_enable) begin
         active_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (active_ff == '0) begin
         live = act_type'(1);
      end else if (active_ff > act_type'(NUM_CORES)) begin
         live = act_type'(NUM_CORES);
      end else begin
         live = active_ff;
      end
   end

   wsts_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .live_cores     (live),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_task_id    (req_task_id),
      .req_core_index (req_core_index),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_re         (ram_re),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_valid      (rsp_valid),
      .rsp_event_kind (rsp_event_kind),
      .rsp_event_core (rsp_event_core),
      .rsp_event_task (rsp_event_task),
      .rsp_last_event (rsp_last_event)
   );

   wsts_ram #(
      .WIDTH (TASK_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_enable  (ram_re),
      .read_addr    (ram_raddr),
      .read_data    (ram_rdata)
   );
endmodule
